### design/lcmn_pkg.sv
// Package: shared constants and types for live cepstral mean normalization.
`default_nettype none
package lcmn_pkg;

  localparam int MAX_VEC_DEF   = 16;
  localparam int FRAC_BITS_DEF = 12;
  localparam int SUM_W         = 44;
  localparam int CNT_W         = 11;
  localparam int MUL_W         = 23;  // full width of the decay scale factor
  localparam logic [CNT_W-1:0] CNT_MAX = 11'd2047;

  // Reset values of the configuration registers
  localparam logic [4:0] VEC_LEN_RST  = 5'd13;
  localparam logic [9:0] WIN_HIGH_RST = 10'd800;
  localparam logic [9:0] WIN_KEEP_RST = 10'd500;

  // Configuration register indexes
  localparam logic [1:0] REG_VEC_LEN  = 2'd0;
  localparam logic [1:0] REG_WIN_HIGH = 2'd1;
  localparam logic [1:0] REG_WIN_KEEP = 2'd2;

  // Input commands
  typedef enum logic [1:0] {
    CMD_NORM   = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_LOAD   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_EXEC,
    ST_CNT,
    ST_W_RD,
    ST_W_DIV,
    ST_W_MUL,
    ST_W_WR,
    ST_W_SF,
    ST_W_RCP,
    ST_W_END
  } state_t;

  // Divider request/response
  typedef struct packed {
    logic            start;
    logic            busy;
    logic            done;
  } div_ctl_t;

endpackage
`default_nettype wire

### design/lcmn_div.sv
// Sequential divider: signed dividend by unsigned count, one quotient bit per cycle.
`default_nettype none
module lcmn_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic signed [lcmn_pkg::SUM_W-1:0] dividend,
  input  wire logic [lcmn_pkg::CNT_W-1:0]  divisor,
  output lcmn_pkg::div_ctl_t               ctl,
  output logic signed [lcmn_pkg::SUM_W-1:0] quotient
);
  import lcmn_pkg::*;

  logic [SUM_W-1:0] rem_q;     // magnitude being shifted out
  logic [CNT_W:0]   part;      // partial remainder
  logic [SUM_W-1:0] quo;
  logic [5:0]       steps;
  logic             neg;
  logic             busy;
  logic             done;
  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   shifted;

  // One restoring step
  always_comb begin
    shifted = {part[CNT_W-1:0], rem_q[SUM_W-1]};
    trial   = shifted - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= 6'(SUM_W);
      end else if (busy) begin
        steps <= steps - 6'd1;
        if (steps == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      neg   <= dividend[SUM_W-1];
      rem_q <= dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
      part  <= '0;
      quo   <= '0;
    end else if (busy) begin
      rem_q <= {rem_q[SUM_W-2:0], 1'b0};
      if (!trial[CNT_W]) begin
        part <= trial;
        quo  <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        part <= shifted;
        quo  <= {quo[SUM_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? -$signed(quo) : $signed(quo);
  assign ctl = '{start: start, busy: busy, done: done};

endmodule
`default_nettype wire

### design/live_cepstral_mean_norm_unit.sv
// Top level: live cepstral mean normalization with APB configuration.
// A normalize or read result is registered into the output register after the read and execute states.
// Input is stalled until the sequencer is idle and the output register is empty; a walk divides each
// element's sum by the count with the 44-step divider, after a reciprocal of the count when the
// window shifts.
// Reset: synchronous; unwritten entries read as reset values (8.0 in element 0) via valid bits.
`default_nettype none
module live_cepstral_mean_norm_unit #(
  parameter int MAX_VEC   = lcmn_pkg::MAX_VEC_DEF,
  parameter int FRAC_BITS = lcmn_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [3:0]  elem_index,
  input  wire logic signed [31:0] sample_value,
  // output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [31:0] out_value,
  output logic             frame_done,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import lcmn_pkg::*;

  localparam int IW = (MAX_VEC > 1) ? $clog2(MAX_VEC) : 1;
  localparam int LW = $clog2(MAX_VEC + 1);
  localparam int SFW = FRAC_BITS + 1 + 10;
  localparam int PRODW = SUM_W + SFW;
  localparam logic signed [31:0] MEAN0_RST = 32'sd8 <<< FRAC_BITS;
  localparam logic signed [SUM_W-1:0] SUM_MAXV = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MINV = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] RCP_NUM = SUM_W'(64'sd1 <<< FRAC_BITS);

  // ---------------- configuration ----------------
  logic [4:0] vec_len;
  logic [9:0] win_high;
  logic [9:0] win_keep;
  logic       cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vec_len  <= VEC_LEN_RST;
      win_high <= WIN_HIGH_RST;
      win_keep <= WIN_KEEP_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_VEC_LEN:  vec_len  <= pwdata[4:0];
        REG_WIN_HIGH: win_high <= pwdata[9:0];
        REG_WIN_KEEP: win_keep <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_VEC_LEN:  prdata = {27'd0, vec_len};
      REG_WIN_HIGH: prdata = {22'd0, win_high};
      REG_WIN_KEEP: prdata = {22'd0, win_keep};
      default:      prdata = '0;
    endcase
  end

  // effective vector length
  logic [LW-1:0] eff_len;
  always_comb begin
    if (vec_len == 5'd0) eff_len = LW'(1);
    else if (32'(vec_len) > MAX_VEC) eff_len = LW'(MAX_VEC);
    else eff_len = LW'(vec_len);
  end

  // ---------------- memories ----------------
  logic signed [31:0]      mean_mem [MAX_VEC];
  logic signed [SUM_W-1:0] sum_mem  [MAX_VEC];
  logic [MAX_VEC-1:0]      mean_vld;
  logic [MAX_VEC-1:0]      sum_vld;
  logic [IW-1:0]           rd_addr;
  logic signed [31:0]      mean_raw;
  logic signed [SUM_W-1:0] sum_raw;
  logic                    mean_rv, sum_rv;
  logic                    mean_we, sum_we;
  logic [IW-1:0]           wr_addr;
  logic signed [31:0]      mean_wd;
  logic signed [SUM_W-1:0] sum_wd;
  logic signed [31:0]      mean_rd;
  logic signed [SUM_W-1:0] sum_rd;

  always_ff @(posedge clk) begin
    mean_raw <= mean_mem[rd_addr];
    sum_raw  <= sum_mem[rd_addr];
    if (mean_we) mean_mem[wr_addr] <= mean_wd;
    if (sum_we)  sum_mem[wr_addr]  <= sum_wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_vld <= '0;
      sum_vld  <= '0;
      mean_rv  <= 1'b0;
      sum_rv   <= 1'b0;
    end else begin
      mean_rv <= mean_vld[rd_addr];
      sum_rv  <= sum_vld[rd_addr];
      if (mean_we) mean_vld[wr_addr] <= 1'b1;
      if (sum_we)  sum_vld[wr_addr]  <= 1'b1;
    end
  end

  // an entry never written reads as its reset value
  logic rd_zero;
  always_ff @(posedge clk) rd_zero <= (rd_addr == '0);
  assign mean_rd = mean_rv ? mean_raw : (rd_zero ? MEAN0_RST : 32'sd0);
  assign sum_rd  = sum_rv  ? sum_raw  : '0;

  // ---------------- sequencer ----------------
  state_t state, state_next;
  logic [1:0]         op;
  logic [IW-1:0]      idx;
  logic signed [31:0] xval;
  logic               idx_ok;
  logic [CNT_W-1:0]   frame_count;
  logic               decay;
  logic [IW-1:0]      walk;
  logic               walking;
  logic [SFW-1:0]     sf;
  logic signed [PRODW-1:0] prod;
  logic signed [SUM_W-1:0] sum_hold;
  logic signed [31:0] res_val;
  logic               res_last;
  logic               out_full;
  logic               in_acc;
  logic               norm_last;

  div_ctl_t               dctl;
  logic                   div_start;
  logic signed [SUM_W-1:0] div_dividend;
  logic signed [SUM_W-1:0] div_q;

  lcmn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (frame_count),
    .ctl      (dctl),
    .quotient (div_q)
  );

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE) || out_full;
  assign norm_last = (32'(idx) == 32'(eff_len) - 1);
  assign walking = state inside {ST_W_SF, ST_W_RCP, ST_W_RD, ST_W_DIV, ST_W_MUL,
                                 ST_W_WR, ST_W_END};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_acc) state_next = ST_RD;
      ST_RD:   state_next = ST_EXEC;
      ST_EXEC: begin
        if (op == CMD_UPDATE) state_next = (frame_count == '0) ? ST_IDLE : ST_W_SF;
        else if (op == CMD_NORM && idx_ok && norm_last) state_next = ST_CNT;
        else state_next = ST_IDLE;
      end
      ST_CNT:   state_next = ST_W_SF;
      ST_W_SF: begin
        if (!((decay || op == CMD_UPDATE) && frame_count != '0)) state_next = ST_IDLE;
        else if (decay) state_next = ST_W_RCP;
        else state_next = ST_W_RD;
      end
      ST_W_RCP: if (dctl.done) state_next = ST_W_RD;
      ST_W_RD:  state_next = ST_W_DIV;
      ST_W_DIV: if (dctl.done) state_next = ST_W_MUL;
      ST_W_MUL: state_next = ST_W_WR;
      ST_W_WR:  state_next = (32'(walk) == 32'(eff_len) - 1) ? ST_W_END : ST_W_RD;
      ST_W_END: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // read address
  always_comb begin
    case (state)
      ST_IDLE: rd_addr = IW'(elem_index);
      default: rd_addr = walking ? walk : idx;
    endcase
  end

  // normalize arithmetic
  logic signed [SUM_W:0] sum_add;
  logic signed [SUM_W-1:0] sum_sat;
  logic signed [32:0]    diff;
  logic signed [31:0]    diff_sat;
  always_comb begin
    sum_add = $signed({sum_rd[SUM_W-1], sum_rd}) + (SUM_W+1)'(xval);
    if (sum_add > (SUM_W+1)'(SUM_MAXV)) sum_sat = SUM_MAXV;
    else if (sum_add < (SUM_W+1)'(SUM_MINV)) sum_sat = SUM_MINV;
    else sum_sat = sum_add[SUM_W-1:0];
    diff = 33'(xval) - 33'(mean_rd);
    if (diff > 33'sd2147483647) diff_sat = 32'sh7fffffff;
    else if (diff < -33'sd2147483648) diff_sat = 32'sh80000000;
    else diff_sat = diff[31:0];
  end

  // quotient saturation to 32 bits
  logic signed [31:0] q_sat;
  always_comb begin
    if (div_q > 44'sd2147483647) q_sat = 32'sh7fffffff;
    else if (div_q < -44'sd2147483648) q_sat = 32'sh80000000;
    else q_sat = div_q[31:0];
  end

  // decay scaling: floor(s*sf/2^F), saturated (exact for sign via floor of signed product)
  logic signed [PRODW-1:0] scaled;
  logic signed [SUM_W-1:0] scaled_sat;
  always_comb begin
    scaled = prod >>> FRAC_BITS;
    if (scaled > PRODW'(SUM_MAXV)) scaled_sat = SUM_MAXV;
    else if (scaled < PRODW'(SUM_MINV)) scaled_sat = SUM_MINV;
    else scaled_sat = scaled[SUM_W-1:0];
  end

  // shared divider: 2^F / count once per shift, then sum / count per element
  assign div_dividend = (state == ST_W_RCP) ? RCP_NUM : sum_rd;
  assign div_start = (state == ST_W_DIV || state == ST_W_RCP) && !dctl.busy && !dctl.done;

  // memory writes
  always_comb begin
    mean_we = 1'b0;
    sum_we  = 1'b0;
    wr_addr = idx;
    mean_wd = xval;
    sum_wd  = sum_sat;
    case (state)
      ST_EXEC: begin
        if (op == CMD_NORM && idx_ok) sum_we = 1'b1;
        if (op == CMD_LOAD && idx_ok) begin
          mean_we = 1'b1;
          sum_we  = 1'b1;
          sum_wd  = SUM_W'(xval) * $signed({1'b0, win_keep});
        end
      end
      ST_W_WR: begin
        wr_addr = walk;
        mean_we = 1'b1;
        mean_wd = q_sat;
        sum_we  = decay;
        sum_wd  = scaled_sat;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_full <= 1'b0;
    else if (state == ST_EXEC && ((op == CMD_NORM && idx_ok) || op == CMD_READ))
      out_full <= 1'b1;
    else if (!out_stall) out_full <= 1'b0;
  end
  assign out_valid = out_full;

  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      res_val  <= (op == CMD_READ) ? (idx_ok ? mean_rd : 32'sd0) : diff_sat;
      res_last <= (op == CMD_NORM) && norm_last;
    end
  end
  assign out_value  = res_val;
  assign frame_done = res_last;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
      decay       <= 1'b0;
    end else begin
      case (state)
        ST_EXEC: begin
          if (op == CMD_LOAD && idx_ok) frame_count <= CNT_W'(win_keep);
          if (op == CMD_UPDATE) decay <= frame_count > CNT_W'(win_high);
        end
        ST_CNT: begin
          if (frame_count < CNT_MAX) begin
            frame_count <= frame_count + CNT_W'(1);
            decay <= (frame_count + CNT_W'(1)) > CNT_W'(win_high);
          end else begin
            decay <= frame_count > CNT_W'(win_high);
          end
        end
        ST_W_END: if (decay) frame_count <= CNT_W'(win_keep);
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op     <= cmd;
      idx    <= IW'(elem_index);
      xval   <= sample_value;
      idx_ok <= 32'(elem_index) < 32'(eff_len);
    end
    if (state == ST_W_SF) walk <= '0;
    if (state == ST_W_RCP && dctl.done)
      sf <= SFW'(div_q[FRAC_BITS:0]) * SFW'(win_keep);
    if (state == ST_W_WR) walk <= walk + IW'(1);
    if (state == ST_W_DIV && div_start) sum_hold <= sum_rd;
    if (state == ST_W_MUL) prod <= PRODW'(sum_hold) * $signed({1'b0, sf});
  end

`ifndef SYNTHESIS
  // result only after a normalize or read
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(op == CMD_NORM || op == CMD_READ))
    else $error("unexpected result");
  // no input taken while the divider works on an element during a walk
  a_walk_stall: assert property (@(posedge clk) disable iff (rst)
    (state == ST_W_DIV) |-> in_stall)
    else $error("input accepted during walk");
  // count drops to win_keep at the end of a walk with decay
  a_keep: assert property (@(posedge clk) disable iff (rst)
    (state == ST_W_END && decay) |=> frame_count == CNT_W'($past(win_keep)))
    else $error("count not reset to win_keep");
`endif

endmodule
`default_nettype wire

### dv/tb_live_cepstral_mean_norm_unit.sv
// Testbench for the live cepstral mean normalization unit with scoreboard and drivers.
`default_nettype none

// Scoreboard: tracks mean/sum/count state and queues expected outputs
class cmn_scoreboard;
  typedef struct {
    logic signed [31:0] value;
    logic               done;
  } norm_out_t;

  longint      mean_q[16];
  longint      sum_q[16];
  int unsigned frame_cnt;
  int unsigned vec_len, win_high, win_keep;
  norm_out_t   pending_q[$];
  int          mismatches;
  int          checked;

  function void reset_state();
    foreach (mean_q[i]) begin
      mean_q[i] = 0;
      sum_q[i]  = 0;
    end
    mean_q[0]  = 64'sd8 <<< 12;
    frame_cnt  = 0;
    vec_len    = 13;
    win_high   = 800;
    win_keep   = 500;
    mismatches = 0;
    checked    = 0;
  endfunction

  function void set_reg(logic [1:0] idx, int unsigned val);
    case (idx)
      lcmn_pkg::REG_VEC_LEN:  vec_len  = val & 32'h1F;
      lcmn_pkg::REG_WIN_HIGH: win_high = val & 32'h3FF;
      lcmn_pkg::REG_WIN_KEEP: win_keep = val & 32'h3FF;
      default: ;
    endcase
  endfunction

  function int unsigned active_len();
    if (vec_len == 0) return 1;
    if (vec_len > 16) return 16;
    return vec_len;
  endfunction

  function longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // floor(s * sf / 2^12), saturated to 44 bits
  function longint decay_sum(longint s, longint unsigned sf);
    bit                neg;
    bit                frac;
    longint unsigned   m, q, low, lowq, lim, t;
    neg  = s < 0;
    m    = neg ? longint'(0) - s : s;
    q    = m >> 12;
    low  = (m & 64'hFFF) * sf;
    lowq = low >> 12;
    frac = (low & 64'hFFF) != 0;
    lim  = 64'd1 << 43;
    if (q != 0 && sf != 0 && q > lim / sf) t = lim;
    else t = q * sf + lowq;
    if (neg) begin
      if (frac) t = t + 1;
      if (t > lim) t = lim;
      return -longint'(t);
    end
    if (t > lim - 1) t = lim - 1;
    return longint'(t);
  endfunction

  function void refresh_means(bit decay);
    int unsigned     n;
    longint unsigned sf;
    n = active_len();
    if (frame_cnt == 0) return;
    for (int i = 0; i < n; i++)
      mean_q[i] = clamp(sum_q[i] / longint'(frame_cnt), -64'sd2147483648, 64'sd2147483647);
    if (decay) begin
      sf = (64'd4096 / frame_cnt) * win_keep;
      for (int i = 0; i < n; i++) sum_q[i] = decay_sum(sum_q[i], sf);
      frame_cnt = win_keep;
    end
  endfunction

  // Accepted input transaction: update state, queue expected output if any
  function void note_input(lcmn_pkg::cmd_t op, logic [3:0] idx, logic signed [31:0] val);
    longint      x;
    int unsigned n;
    bit          in_range;
    norm_out_t   r;
    x        = longint'(val);
    n        = active_len();
    in_range = idx < n;
    case (op)
      lcmn_pkg::CMD_NORM: begin
        if (!in_range) return;
        sum_q[idx] = clamp(sum_q[idx] + x, -(64'sd1 <<< 43), (64'sd1 <<< 43) - 1);
        r.value = clamp(x - mean_q[idx], -64'sd2147483648, 64'sd2147483647);
        r.done  = (idx == n - 1);
        pending_q.push_back(r);
        if (r.done) begin
          if (frame_cnt < 2047) frame_cnt++;
          if (frame_cnt > win_high) refresh_means(1'b1);
        end
      end
      lcmn_pkg::CMD_UPDATE: begin
        if (frame_cnt != 0) refresh_means(frame_cnt > win_high);
      end
      lcmn_pkg::CMD_LOAD: begin
        if (!in_range) return;
        mean_q[idx] = x;
        sum_q[idx]  = x * longint'(win_keep);
        frame_cnt   = win_keep;
      end
      default: begin
        r.value = in_range ? mean_q[idx][31:0] : 32'sd0;
        r.done  = 1'b0;
        pending_q.push_back(r);
      end
    endcase
  endfunction

  // Accepted output transaction: compare with oldest expectation
  function void check_result(logic signed [31:0] val, logic done);
    norm_out_t r;
    checked++;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: unexpected output value=%0d frame_done=%0b", val, done);
      return;
    end
    r = pending_q.pop_front();
    if (val !== r.value || done !== r.done) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: expected value=%0d frame_done=%0b, got value=%0d frame_done=%0b",
                 r.value, r.done, val, done);
    end
  endfunction
endclass

module tb_live_cepstral_mean_norm_unit;
  import lcmn_pkg::*;

  localparam int CYCLE_LIMIT   = 3000000;
  localparam int SETTLE_CYCLES = 1000;  // longest walk: 16 elements plus reciprocal

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         cmd;
  logic [3:0]         elem_index;
  logic signed [31:0] sample_value;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_value;
  logic               frame_done;
  logic               psel, penable, pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  cmn_scoreboard sb;
  int            gap_pct;
  int            stall_pct;
  int            cycles;
  int            sent;
  int            sweep_pos;

  live_cepstral_mean_norm_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .elem_index(elem_index), .sample_value(sample_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_value(out_value), .frame_done(frame_done),
    .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Output stall generation
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Output monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_value, frame_done);
  end

  // Send one input transaction, with optional idle gap first
  task automatic send_item(cmd_t op, logic [3:0] idx, logic signed [31:0] val);
    while ($urandom_range(0, 99) < gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    cmd          <= op;
    elem_index   <= idx;
    sample_value <= val;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note_input(op, idx, val);
    sent++;
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // APB register write: setup then access
  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Wait for all outputs plus the longest silent walk
  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return $signed(32'($urandom_range(0, 65535))) - 32768;
    if (sel < 52) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7FFFFFFF;
        1: return 32'sh80000000;
        2: return -1;
        default: return 0;
      endcase
    end
    return $signed($urandom());
  endfunction

  // Random traffic: mostly in-order vector sweeps, some commands and noise
  task automatic random_item();
    int          sel;
    int unsigned n;
    n   = sb.active_len();
    sel = $urandom_range(0, 99);
    if (sel < 80) begin
      if (sweep_pos >= n) sweep_pos = 0;
      send_item(CMD_NORM, 4'(sweep_pos), pick_value());
      sweep_pos++;
    end else if (sel < 83) begin
      send_item(CMD_UPDATE, 4'($urandom_range(0, 15)), pick_value());
    end else if (sel < 88) begin
      send_item(CMD_LOAD, 4'($urandom_range(0, n - 1)), pick_value());
    end else if (sel < 95) begin
      send_item(CMD_READ, 4'($urandom_range(0, 15)), pick_value());
    end else begin
      send_item(cmd_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), $signed($urandom()));
    end
  endtask

  initial begin
    int cfg_len[6];
    int cfg_high[6];
    int cfg_keep[6];
    int gaps[4];
    int stalls[4];
    sb = new();
    sb.reset_state();
    cfg_len  = '{13, 1, 16, 4, 16, 7};
    cfg_high = '{800, 1, 1023, 5, 20, 1023};
    cfg_keep = '{500, 1, 1023, 3, 10, 1};
    gaps     = '{0, 71, 0, 38};
    stalls   = '{0, 0, 71, 38};
    sent     = 0;
    sweep_pos = 0;
    gap_pct  = 0;
    stall_pct = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = CMD_NORM;
    elem_index = '0;
    sample_value = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset mean, range edges, saturation, update, load, frame close
    send_item(CMD_READ, 4'd0, 0);
    send_item(CMD_READ, 4'd15, 0);
    send_item(CMD_UPDATE, 4'd0, 0);
    send_item(CMD_NORM, 4'd0, 32'sh7FFFFFFF);
    send_item(CMD_NORM, 4'd1, 32'sh80000000);
    send_item(CMD_LOAD, 4'd2, 32'sh7FFFFFFF);
    send_item(CMD_NORM, 4'd2, 32'sh80000000);
    send_item(CMD_NORM, 4'd14, 32'sh12345678);
    send_item(CMD_LOAD, 4'd15, 32'sh0000_1000);
    send_item(CMD_READ, 4'd13, 0);
    for (int i = 3; i < 13; i++) send_item(CMD_NORM, 4'(i), 32'(i * 4096 - 20000));
    send_item(CMD_UPDATE, 4'd0, 0);
    send_item(CMD_READ, 4'd2, 0);
    send_item(CMD_LOAD, 4'd5, -1);
    send_item(CMD_READ, 4'd5, 0);
    send_item(CMD_READ, 4'd12, 0);
    drop_valid();
    drain();

    // Random phases over register settings and idling patterns
    for (int p = 0; p < 6; p++) begin
      reg_write(REG_VEC_LEN, cfg_len[p]);
      reg_write(REG_WIN_HIGH, cfg_high[p]);
      reg_write(REG_WIN_KEEP, cfg_keep[p]);
      gap_pct   = gaps[p % 4];
      stall_pct = stalls[p % 4];
      sweep_pos = 0;
      for (int k = 0; k < 280; k++) random_item();
      drop_valid();
      drain();
    end
    stall_pct = 0;
    drain();

    $display("Sent %0d transactions over 6 register settings, %0d outputs checked",
             sent, sb.checked);
    $display("Covered idle/stall mixes, window shifts, updates, loads and reads");
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d outputs missing", sb.mismatches, sb.pending_q.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
design/lcmn_pkg.sv
design/lcmn_div.sv
design/live_cepstral_mean_norm_unit.sv
dv/tb_live_cepstral_mean_norm_unit.sv
